/* rtl/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and codes for the collision risk screen: request and decision
// codes, register map, configuration bundle and controller/datapath links.
// ----------------------------------------------------------------------------
package crs_pkg;

  // request codes carried by req_type
  localparam logic [1:0] REQ_ADD_OBJECT   = 2'd0;
  localparam logic [1:0] REQ_ADD_OBSTACLE = 2'd1;
  localparam logic [1:0] REQ_CHECK        = 2'd2;

  // decision codes
  typedef enum logic [1:0] {
    DEC_CRUISE = 2'd0,
    DEC_BRAKE  = 2'd1,
    DEC_SLOW   = 2'd2
  } dec_t;

  // register map, word index (byte address / 4)
  localparam int          APB_AW            = 4;
  localparam logic [1:0]  REG_NEAR_DISTANCE = 2'd0;
  localparam logic [1:0]  REG_OBST_MARGIN   = 2'd1;
  localparam logic [1:0]  REG_SLOW_SPEED    = 2'd2;
  localparam logic [1:0]  REG_HORIZON       = 2'd3;

  // reset values
  localparam logic [15:0] NEAR_DISTANCE_RST = 16'd1280;   // 5.0 m
  localparam logic [15:0] OBST_MARGIN_RST   = 16'd512;    // 2.0 m
  localparam logic [15:0] SLOW_SPEED_RST    = 16'd3072;   // 12.0 m/s
  localparam logic [2:0]  HORIZON_RST       = 3'd2;

  typedef struct packed {
    logic [15:0] near_distance;
    logic [15:0] obstacle_margin;
    logic [15:0] slow_speed;
    logic [2:0]  horizon_seconds;
  } cfg_t;

  // controller state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_OBJ,
    ST_WALK_OBS,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic obj_rd;     // read object entry at obj_addr
    logic obs_rd;     // read obstacle entry at obs_addr
    logic load_out;   // move pending result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;  // compare pipeline still holds entries
  } stat_t;

endpackage

/* rtl/crs_regs.sv */
// ----------------------------------------------------------------------------
// crs_regs
// APB register file holding the screen thresholds and prediction horizon.
// ----------------------------------------------------------------------------
module crs_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output crs_pkg::cfg_t              cfg
);
  import crs_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_distance   <= NEAR_DISTANCE_RST;
      cfg.obstacle_margin <= OBST_MARGIN_RST;
      cfg.slow_speed      <= SLOW_SPEED_RST;
      cfg.horizon_seconds <= HORIZON_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NEAR_DISTANCE: cfg.near_distance   <= pwdata[15:0];
        REG_OBST_MARGIN:   cfg.obstacle_margin <= pwdata[15:0];
        REG_SLOW_SPEED:    cfg.slow_speed      <= pwdata[15:0];
        REG_HORIZON:       cfg.horizon_seconds <= pwdata[2:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_NEAR_DISTANCE: prdata = {16'd0, cfg.near_distance};
      REG_OBST_MARGIN:   prdata = {16'd0, cfg.obstacle_margin};
      REG_SLOW_SPEED:    prdata = {16'd0, cfg.slow_speed};
      REG_HORIZON:       prdata = {29'd0, cfg.horizon_seconds};
    endcase
  end

endmodule

/* rtl/crs_ctrl.sv */
// ----------------------------------------------------------------------------
// crs_ctrl
// Request sequencer: takes requests, walks the object and obstacle tables
// for a check, waits for the compare pipeline to empty and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module crs_ctrl #(
  parameter int OBJECT_SLOTS   = 32,
  parameter int OBSTACLE_SLOTS = 32,
  parameter int OBJ_AW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1,
  parameter int OBS_AW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1,
  parameter int OBJ_CW = $clog2(OBJECT_SLOTS + 1),
  parameter int OBS_CW = $clog2(OBSTACLE_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_type,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic [OBJ_CW-1:0]  obj_count,
  input  logic [OBS_CW-1:0]  obs_count,
  input  crs_pkg::stat_t     stat,
  output crs_pkg::cmd_t      cmd,
  output logic [OBJ_AW-1:0]  obj_addr,
  output logic [OBS_AW-1:0]  obs_addr
);
  import crs_pkg::*;

  localparam int IW = (OBJ_CW > OBS_CW) ? OBJ_CW : OBS_CW;

  state_t        state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] obj_cnt_e, obs_cnt_e;
  logic          obj_last, obs_last;
  logic          out_free;

  assign obj_cnt_e = IW'(obj_count);
  assign obs_cnt_e = IW'(obs_count);
  assign idx_inc   = idx + IW'(1);
  // last entry of a table, or an empty table
  assign obj_last  = (idx_inc >= obj_cnt_e);
  assign obs_last  = (idx_inc >= obs_cnt_e);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign obj_addr  = idx[OBJ_AW-1:0];
  assign obs_addr  = idx[OBS_AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_type == REQ_CHECK) ? ST_WALK_OBJ : ST_RESULT;
        end
      end
      ST_WALK_OBJ: begin
        if (obj_last) state_next = ST_WALK_OBS;
      end
      ST_WALK_OBS: begin
        if (obs_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // walk index
  always_comb begin
    idx_next = '0;
    if ((state == ST_WALK_OBJ && !obj_last) || (state == ST_WALK_OBS && !obs_last)) begin
      idx_next = idx_inc;
    end
  end

  // commands
  always_comb begin
    req_stall    = (state != ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && req_valid;
    cmd.obj_rd   = (state == ST_WALK_OBJ) && (idx < obj_cnt_e);
    cmd.obs_rd   = (state == ST_WALK_OBS) && (idx < obs_cnt_e);
    cmd.load_out = (state == ST_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/crs_datapath.sv */
// ----------------------------------------------------------------------------
// crs_datapath
// Entry tables, fill counts and the five-stage distance compare pipeline:
// table read, offset and velocity scaling, prediction, squaring, and the
// squared distance compare that feeds the risk flag.
// ----------------------------------------------------------------------------
module crs_datapath #(
  parameter int OBJECT_SLOTS   = 32,
  parameter int OBSTACLE_SLOTS = 32,
  parameter int OBJ_AW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1,
  parameter int OBS_AW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1,
  parameter int OBJ_CW = $clog2(OBJECT_SLOTS + 1),
  parameter int OBS_CW = $clog2(OBSTACLE_SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  crs_pkg::cmd_t      cmd,
  input  crs_pkg::cfg_t      cfg,
  input  logic [1:0]         req_type,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [15:0]        radius,
  input  logic [15:0]        host_speed,
  input  logic [OBJ_AW-1:0]  obj_addr,
  input  logic [OBS_AW-1:0]  obs_addr,
  output logic [OBJ_CW-1:0]  obj_count,
  output logic [OBS_CW-1:0]  obs_count,
  output crs_pkg::stat_t     stat,
  output logic               status,
  output logic [4:0]         entry_index,
  output logic               risk_alert,
  output logic [1:0]         decision,
  output logic               safety_ok
);
  import crs_pkg::*;

  // tables
  logic [79:0] obj_mem [OBJECT_SLOTS];   // {px, py, vx, vy}
  logic [63:0] obs_mem [OBSTACLE_SLOTS]; // {px, py, r}
  logic        obj_full, obs_full;

  // request context
  logic signed [23:0] ego_x, ego_y;
  logic [15:0]        ego_spd;
  logic               pend_check, pend_status;
  logic [4:0]         pend_index;
  logic [31:0]        nd2;
  logic               hit;

  // pipeline
  logic               v0, v1, v2, v3;
  logic               k0, k1, k2, k3;   // 1 = obstacle entry
  logic [79:0]        obj_q;
  logic [63:0]        obs_q;
  logic signed [23:0] s1_px, s1_py;
  logic signed [15:0] s1_vx, s1_vy;
  logic signed [19:0] s1_vx_e, s1_vy_e, s1_h_e;
  logic signed [19:0] vh_x_next, vh_y_next;
  logic signed [24:0] dx1, dy1, dx2, dy2;
  logic signed [18:0] vhx1, vhy1;
  logic [16:0]        t1, t2;
  logic signed [25:0] fx2, fy2;
  logic signed [49:0] sq_dx_w, sq_dy_w;
  logic signed [51:0] sq_fx_w, sq_fy_w;
  logic [47:0]        sq_dx, sq_dy;
  logic [49:0]        sq_fx, sq_fy;
  logic [33:0]        tt3;
  logic [48:0]        d_now;
  logic [50:0]        d_fut;
  logic [33:0]        thr;
  logic               now_hit, fut_hit;

  assign obj_full = (obj_count == OBJ_CW'(OBJECT_SLOTS));
  assign obs_full = (obs_count == OBS_CW'(OBSTACLE_SLOTS));
  assign stat.pipe_busy = v0 || v1 || v2 || v3;

  // table writes and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_count <= '0;
      obs_count <= '0;
    end else if (cmd.accept) begin
      if (req_type == REQ_ADD_OBJECT && !obj_full) begin
        obj_count <= obj_count + OBJ_CW'(1);
      end
      if (req_type == REQ_ADD_OBSTACLE && !obs_full) begin
        obs_count <= obs_count + OBS_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == REQ_ADD_OBJECT && !obj_full) begin
      obj_mem[obj_count[OBJ_AW-1:0]] <= {pos_x, pos_y, vel_x, vel_y};
    end
    if (cmd.obj_rd) begin
      obj_q <= obj_mem[obj_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req_type == REQ_ADD_OBSTACLE && !obs_full) begin
      obs_mem[obs_count[OBS_AW-1:0]] <= {pos_x, pos_y, radius};
    end
    if (cmd.obs_rd) begin
      obs_q <= obs_mem[obs_addr];
    end
  end

  // request context and add result
  always_ff @(posedge clk) begin
    nd2 <= cfg.near_distance * cfg.near_distance;
    if (cmd.accept) begin
      ego_x       <= pos_x;
      ego_y       <= pos_y;
      ego_spd     <= host_speed;
      pend_check  <= (req_type == REQ_CHECK);
      pend_status <= 1'b0;
      pend_index  <= '0;
      unique case (req_type)
        REQ_ADD_OBJECT: begin
          if (obj_full) pend_status <= 1'b1;
          else          pend_index  <= 5'(obj_count);
        end
        REQ_ADD_OBSTACLE: begin
          if (obs_full) pend_status <= 1'b1;
          else          pend_index  <= 5'(obs_count);
        end
        default: ;
      endcase
    end
  end

  // stage 1: offsets from ego, velocity times horizon, clearance
  assign s1_px     = k0 ? $signed(obs_q[63:40]) : $signed(obj_q[79:56]);
  assign s1_py     = k0 ? $signed(obs_q[39:16]) : $signed(obj_q[55:32]);
  assign s1_vx     = $signed(obj_q[31:16]);
  assign s1_vy     = $signed(obj_q[15:0]);
  assign s1_vx_e   = 20'(s1_vx);
  assign s1_vy_e   = 20'(s1_vy);
  assign s1_h_e    = $signed({17'd0, cfg.horizon_seconds});
  assign vh_x_next = s1_vx_e * s1_h_e;
  assign vh_y_next = s1_vy_e * s1_h_e;

  // stage 3 squares, stage 4 sums and compares
  assign sq_dx_w = dx2 * dx2;
  assign sq_dy_w = dy2 * dy2;
  assign sq_fx_w = fx2 * fx2;
  assign sq_fy_w = fy2 * fy2;

  assign d_now   = {1'b0, sq_dx} + {1'b0, sq_dy};
  assign d_fut   = {1'b0, sq_fx} + {1'b0, sq_fy};
  assign thr     = k3 ? tt3 : {2'd0, nd2};
  assign now_hit = (d_now < {15'd0, thr});
  assign fut_hit = !k3 && (d_fut < {19'd0, nd2});

  always_ff @(posedge clk) begin
    // stage 1
    dx1  <= 25'(s1_px) - 25'(ego_x);
    dy1  <= 25'(s1_py) - 25'(ego_y);
    vhx1 <= vh_x_next[18:0];
    vhy1 <= vh_y_next[18:0];
    t1   <= {1'b0, obs_q[15:0]} + {1'b0, cfg.obstacle_margin};
    // stage 2: predicted offsets
    dx2  <= dx1;
    dy2  <= dy1;
    fx2  <= 26'(dx1) + 26'(vhx1);
    fy2  <= 26'(dy1) + 26'(vhy1);
    t2   <= t1;
    // stage 3: squares
    sq_dx <= sq_dx_w[47:0];
    sq_dy <= sq_dy_w[47:0];
    sq_fx <= sq_fx_w[49:0];
    sq_fy <= sq_fy_w[49:0];
    tt3   <= t2 * t2;
    k1 <= k0;
    k2 <= k1;
    k3 <= k2;
  end

  // pipeline valids and risk flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      k0  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v0 <= cmd.obj_rd || cmd.obs_rd;
      k0 <= cmd.obs_rd;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (cmd.accept) begin
        hit <= 1'b0;
      end else if (v3 && (now_hit || fut_hit)) begin
        hit <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= pend_status;
      entry_index    <= pend_index;
      risk_alert     <= pend_check && hit;
      safety_ok      <= pend_check && !hit;
      if (!pend_check)               decision <= DEC_CRUISE;
      else if (hit)                  decision <= DEC_BRAKE;
      else if (ego_spd > cfg.slow_speed) decision <= DEC_SLOW;
      else                           decision <= DEC_CRUISE;
    end
  end

endmodule

/* rtl/collision_risk_screen.sv */
// ----------------------------------------------------------------------------
// collision_risk_screen
// Table-based collision risk screen over stored objects and obstacles.
// ----------------------------------------------------------------------------
// One request is in work at a time; it is taken while the previous result
// still waits in the output register. For an add, the entry is written when
// the request is taken, and the result is loaded from ST_RESULT once the
// output register is free. A check reads one table entry per cycle from the
// single read port of each table, and the five-stage compare pipeline must
// empty before the risk flag is final. Positions are Q15.8 m, speeds and
// radii Q8.8; all comparisons use exact squared distances. Registers sit at
// byte addresses 0 (near_distance), 4 (obstacle_margin), 8 (slow_speed) and
// 12 (horizon_seconds).
module collision_risk_screen #(
  parameter int OBJECT_SLOTS   = 32,
  parameter int OBSTACLE_SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 req_type,
  input  logic signed [23:0]         pos_x,
  input  logic signed [23:0]         pos_y,
  input  logic signed [15:0]         vel_x,
  input  logic signed [15:0]         vel_y,
  input  logic [15:0]                radius,
  input  logic [15:0]                host_speed,
  // result channel
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       status,
  output logic [4:0]                 entry_index,
  output logic                       risk_alert,
  output logic [1:0]                 decision,
  output logic                       safety_ok,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import crs_pkg::*;

  localparam int OBJ_AW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam int OBS_AW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;
  localparam int OBJ_CW = $clog2(OBJECT_SLOTS + 1);
  localparam int OBS_CW = $clog2(OBSTACLE_SLOTS + 1);

  cfg_t              cfg;
  cmd_t              cmd;
  stat_t             stat;
  logic [OBJ_CW-1:0] obj_count;
  logic [OBS_CW-1:0] obs_count;
  logic [OBJ_AW-1:0] obj_addr;
  logic [OBS_AW-1:0] obs_addr;

  crs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crs_ctrl #(
    .OBJECT_SLOTS   (OBJECT_SLOTS),
    .OBSTACLE_SLOTS (OBSTACLE_SLOTS),
    .OBJ_AW         (OBJ_AW),
    .OBS_AW         (OBS_AW),
    .OBJ_CW         (OBJ_CW),
    .OBS_CW         (OBS_CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .obj_count (obj_count),
    .obs_count (obs_count),
    .stat      (stat),
    .cmd       (cmd),
    .obj_addr  (obj_addr),
    .obs_addr  (obs_addr)
  );

  crs_datapath #(
    .OBJECT_SLOTS   (OBJECT_SLOTS),
    .OBSTACLE_SLOTS (OBSTACLE_SLOTS),
    .OBJ_AW         (OBJ_AW),
    .OBS_AW         (OBS_AW),
    .OBJ_CW         (OBJ_CW),
    .OBS_CW         (OBS_CW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .req_type       (req_type),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .radius         (radius),
    .host_speed     (host_speed),
    .obj_addr       (obj_addr),
    .obs_addr       (obs_addr),
    .obj_count      (obj_count),
    .obs_count      (obs_count),
    .stat           (stat),
    .status         (status),
    .entry_index    (entry_index),
    .risk_alert     (risk_alert),
    .decision       (decision),
    .safety_ok      (safety_ok)
  );

endmodule
